// ----- hw/rtl/ccsh_pkg.sv -----
// ccsh_pkg: shared types and constants of the consensus / hamming distance core
// beat structs, counter widths, opcodes and controller <-> datapath signal groups
// no dependencies
`timescale 1ns / 1ps

package ccsh_pkg;

  // sizes
  localparam int MaxLen   = 64;
  localparam int ColW     = $clog2(MaxLen);
  localparam int LenW     = ColW + 1;
  localparam int NumBases = 4;
  localparam int BaseW    = 2;
  localparam int CntW     = 11;
  localparam int SumW     = CntW + 2;
  localparam int MisW     = 11;
  localparam int DistW    = 17;
  localparam int RowW     = NumBases * CntW;

  localparam logic [CntW-1:0]  CntMax  = '1;
  localparam logic [MisW-1:0]  MisMax  = '1;
  localparam logic [DistW-1:0] DistMax = '1;
  localparam logic [LenW-1:0]  LenMax  = LenW'(MaxLen);

  // nucleotide codes
  localparam logic [BaseW-1:0] BaseA = 2'd0;
  localparam logic [BaseW-1:0] BaseC = 2'd1;
  localparam logic [BaseW-1:0] BaseG = 2'd2;
  localparam logic [BaseW-1:0] BaseT = 2'd3;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // input beat
  typedef struct packed {
    op_e             op;
    logic [ColW-1:0] column;
    logic [BaseW-1:0] base;
  } item_t;

  // result beat
  typedef struct packed {
    logic [ColW-1:0]  out_column;
    logic [BaseW-1:0] consensus_base;
    logic [MisW-1:0]  column_mismatches;
    logic [DistW-1:0] total_distance;
    logic             last;
  } res_t;

  // one memory row: the four base counters of a column
  typedef logic [NumBases-1:0][CntW-1:0] cnt_row_t;

  // controller to datapath
  typedef struct packed {
    logic            rd_en;       // read a counter row
    logic            rd_from_in;  // row address from the input beat (load)
    logic [ColW-1:0] rd_col;      // row address during the finish walk
    logic            rd_last;     // this walk read is the final column
    logic            load_cap;    // capture the load beat
    logic            wr_en;       // write back the incremented row
    logic            fin_begin;   // clear the running distance
    logic            clr_rows;    // drop every row valid bit
  } ccsh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [LenW-1:0] ncols;       // clamped column count
    logic            pipe_busy;   // walk results still in flight
  } ccsh_stat_t;

endpackage

// ----- hw/rtl/consensus_sequence_hamming_core.sv -----
// consensus_sequence_hamming_core: top level, joins the sequencer and the datapath
// depends on ccsh_pkg, ccsh_ctrl, ccsh_dp
//
//   channel   ports                                   beat taken when
//   ------    -------------------------------------   ---------------------
//   command   start, busy, item_i (item_t)            start && !busy
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i    cfg_valid_i && cfg_ready_o
//   result    res_valid_o, res_o (res_t)              res_valid_o, one cycle
//
// a load reads the counter row from the single ram and writes it back incremented
// in the same cycle that its registered read returns
// a finish over n columns reads one row per cycle, then three pipeline stages
// (ram read, max/sum, mismatch/distance) drain; results are n beats on consecutive
// cycles, and the row valid bits are all cleared in the cycle of the last result beat
// a finish with zero columns gives no result beats
// reset clears control state and row valid bits at once; no clearing pass is needed
// the result side cannot stall; the block never holds a result
`timescale 1ns / 1ps

module consensus_sequence_hamming_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ccsh_pkg::item_t            item_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ccsh_pkg::LenW-1:0]  cfg_data_i,
  output logic                       res_valid_o,
  output ccsh_pkg::res_t             res_o
);

  import ccsh_pkg::*;

  ccsh_cmd_t  cmd;
  ccsh_stat_t stat;

  // sequencer
  ccsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .op_i        (item_i.op),
    .busy        (busy),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // counters and consensus pipeline
  ccsh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ----- hw/rtl/ccsh_ram.sv -----
// ccsh_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ccsh_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ccsh_ctrl.sv -----
// ccsh_ctrl: sequencer for load read-modify-write and the finish column walk
// depends on ccsh_pkg
`timescale 1ns / 1ps

module ccsh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ccsh_pkg::op_e       op_i,
  output logic                busy,
  output logic                cfg_ready_o,
  output ccsh_pkg::ccsh_cmd_t cmd_o,
  input  ccsh_pkg::ccsh_stat_t stat_i
);

  import ccsh_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_FIN_RD,
    ST_DRAIN
  } state_e;

  state_e          state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic            accept;
  logic            walk_last;

  assign accept    = start && (state_q == ST_IDLE);
  assign walk_last = ({1'b0, col_q} + LenW'(1)) == stat_i.ncols;

  // next state and commands
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    cmd_o   = '0;
    cmd_o.rd_col  = col_q;
    cmd_o.rd_last = walk_last;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_LOAD) begin
            cmd_o.rd_en      = 1'b1;
            cmd_o.rd_from_in = 1'b1;
            cmd_o.load_cap   = 1'b1;
            state_d          = ST_LOAD_WR;
          end else begin
            cmd_o.fin_begin = 1'b1;
            col_d           = '0;
            state_d         = ST_FIN_RD;
          end
        end
      end
      ST_LOAD_WR: begin
        cmd_o.wr_en = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_FIN_RD: begin
        if (stat_i.ncols == '0) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.rd_en = 1'b1;
          col_d       = col_q + ColW'(1);
          if (walk_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.clr_rows = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

endmodule

// ----- hw/rtl/ccsh_dp.sv -----
// ccsh_dp: counter memory, row valid bits, length register and consensus pipeline
// depends on ccsh_pkg and ccsh_ram
`timescale 1ns / 1ps

module ccsh_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccsh_pkg::item_t      item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [ccsh_pkg::LenW-1:0] cfg_data_i,
  input  ccsh_pkg::ccsh_cmd_t  cmd_i,
  output ccsh_pkg::ccsh_stat_t stat_o,
  output logic                 res_valid_o,
  output ccsh_pkg::res_t       res_o
);

  import ccsh_pkg::*;

  logic [LenW-1:0]    seq_len_q;
  logic [MaxLen-1:0]  row_vld_q;
  logic [ColW-1:0]    raddr;
  logic [RowW-1:0]    rdata;
  cnt_row_t           cur_row;
  cnt_row_t           new_row;
  logic               rd_row_vld_q;

  // captured load beat
  logic [ColW-1:0]    ld_col_q;
  logic [BaseW-1:0]   ld_base_q;

  // walk stage 1: row read in flight
  logic               rd_vld_q;
  logic               rd_last_q;
  logic [ColW-1:0]    rd_col_q;

  // walk stage 2: per column stats
  logic               st_vld_q;
  logic               st_last_q;
  logic [ColW-1:0]    st_col_q;
  logic [BaseW-1:0]   st_best_q;
  logic [CntW-1:0]    st_max_q;
  logic [SumW-1:0]    st_sum_q;
  logic [BaseW-1:0]   best;
  logic [CntW-1:0]    maxc;
  logic [SumW-1:0]    sum;

  // walk stage 3: mismatches and running distance
  logic [SumW-1:0]    mis_raw;
  logic [MisW-1:0]    mis_sat;
  logic [DistW:0]     dist_raw;
  logic [DistW-1:0]   dist_sat;
  logic [DistW-1:0]   total_q;
  logic               res_valid_q;
  res_t               res_q;

  // length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= LenMax;
    end else if (cfg_valid_i && cfg_ready_i) begin
      seq_len_q <= cfg_data_i;
    end
  end

  assign stat_o = '{ncols:     (seq_len_q > LenMax) ? LenMax : seq_len_q,
                    pipe_busy: rd_vld_q || st_vld_q};

  // counter memory
  assign raddr = cmd_i.rd_from_in ? item_i.column : cmd_i.rd_col;

  ccsh_ram #(
    .Width (RowW),
    .Depth (MaxLen)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (ld_col_q),
    .wdata_i (new_row),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // a row never written since the last finish reads as zero
  assign cur_row = rd_row_vld_q ? cnt_row_t'(rdata) : '0;

  // row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.clr_rows) begin
      row_vld_q <= '0;
    end else if (cmd_i.wr_en) begin
      row_vld_q[ld_col_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_row_vld_q <= row_vld_q[raddr];
    end
  end

  // load beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cap) begin
      ld_col_q  <= item_i.column;
      ld_base_q <= item_i.base;
    end
  end

  // saturating increment of one lane
  always_comb begin
    new_row = cur_row;
    if (cur_row[ld_base_q] != CntMax) begin
      new_row[ld_base_q] = cur_row[ld_base_q] + CntW'(1);
    end
  end

  // max search with ties to the lower base code, and the column total
  always_comb begin
    best = BaseA;
    maxc = cur_row[BaseA];
    sum  = SumW'(cur_row[BaseA]);
    for (int i = 1; i < NumBases; i++) begin
      sum = sum + SumW'(cur_row[i]);
      if (cur_row[i] > maxc) begin
        maxc = cur_row[i];
        best = BaseW'(i);
      end
    end
  end

  // mismatch and distance saturation
  assign mis_raw  = st_sum_q - SumW'(st_max_q);
  assign mis_sat  = (mis_raw > SumW'(MisMax)) ? MisMax : mis_raw[MisW-1:0];
  assign dist_raw = {1'b0, total_q} + (DistW + 1)'(mis_sat);
  assign dist_sat = dist_raw[DistW] ? DistMax : dist_raw[DistW-1:0];

  // walk pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      st_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= cmd_i.rd_en && !cmd_i.rd_from_in;
      st_vld_q    <= rd_vld_q;
      res_valid_q <= st_vld_q;
    end
  end

  // walk pipeline payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_last_q <= cmd_i.rd_last;
      rd_col_q  <= cmd_i.rd_col;
    end
    if (rd_vld_q) begin
      st_last_q <= rd_last_q;
      st_col_q  <= rd_col_q;
      st_best_q <= best;
      st_max_q  <= maxc;
      st_sum_q  <= sum;
    end
    if (cmd_i.fin_begin) begin
      total_q <= '0;
    end else if (st_vld_q) begin
      total_q <= dist_sat;
    end
    if (st_vld_q) begin
      res_q.out_column        <= st_col_q;
      res_q.consensus_base    <= st_best_q;
      res_q.column_mismatches <= mis_sat;
      res_q.total_distance    <= dist_sat;
      res_q.last              <= st_last_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hw/rtl/ccsh_checker.sv -----
// ccsh_checker: port level assertions for the consensus core, bound to the top level
// depends on ccsh_pkg and consensus_sequence_hamming_core
`timescale 1ns / 1ps

module ccsh_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            res_valid_o,
  input ccsh_pkg::res_t  res_o
);

  import ccsh_pkg::*;

  // an accepted command always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted command");

  // results only appear while a finish is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result beat while idle");

  // result beats of one finish come back to back with rising columns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=>
      res_valid_o && (res_o.out_column == $past(res_o.out_column) + ColW'(1)))
    else $error("result burst broken or column out of order");

  // the last beat ends the burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result beat after last");

endmodule

bind consensus_sequence_hamming_core ccsh_checker u_ccsh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ----- tb/sv/tb_consensus_sequence_hamming_core.sv -----
// tb_consensus_sequence_hamming_core: self-checking bench for the consensus / hamming core
// drives load and finish beats, predicts every result beat in-bench and compares per field
// depends on ccsh_pkg and consensus_sequence_hamming_core
`timescale 1ns / 1ps

module tb_consensus_sequence_hamming_core;
  import ccsh_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomItems  = 380;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  item_t            item_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_data_i;
  logic             res_valid_o;
  res_t             res_o;

  // bench copy of the counters and the length register
  logic [CntW-1:0]  col_counts [MaxLen][NumBases];
  logic [LenW-1:0]  model_len;
  res_t             consensus_q [$];
  res_t             want_res;

  int unsigned      n_errors;
  int unsigned      n_items;
  int unsigned      burst_left;
  int unsigned      cycle_cnt;

  consensus_sequence_hamming_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_counts();
    for (int c = 0; c < MaxLen; c++) begin
      for (int b = 0; b < NumBases; b++) begin
        col_counts[c][b] = '0;
      end
    end
  endfunction

  // saturating increment of one counter
  function automatic void tally_nucleotide(input item_t it);
    if (col_counts[it.column][it.base] != CntMax) begin
      col_counts[it.column][it.base] = col_counts[it.column][it.base] + 1'b1;
    end
  endfunction

  // walk the columns in use, queue one result per column, then clear
  function automatic void emit_consensus();
    int unsigned ncols;
    int unsigned best;
    int unsigned top;
    int unsigned sum;
    int unsigned mis;
    int unsigned total;
    res_t        r;
    ncols = (model_len > LenMax) ? MaxLen : model_len;
    total = 0;
    for (int unsigned c = 0; c < ncols; c++) begin
      best = 0;
      top  = col_counts[c][0];
      sum  = top;
      // strict compare keeps ties on the earlier base
      for (int unsigned b = 1; b < NumBases; b++) begin
        sum += col_counts[c][b];
        if (col_counts[c][b] > top) begin
          top  = col_counts[c][b];
          best = b;
        end
      end
      mis = sum - top;
      if (mis > MisMax) mis = MisMax;
      total += mis;
      if (total > DistMax) total = DistMax;
      r.out_column        = ColW'(c);
      r.consensus_base    = BaseW'(best);
      r.column_mismatches = MisW'(mis);
      r.total_distance    = DistW'(total);
      r.last              = (c + 1 == ncols);
      consensus_q.push_back(r);
    end
    clear_counts();
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: the block cannot be stalled, every strobe is a beat
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [DistW-1:0] want,
                                      input logic [DistW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (consensus_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, res_o);
        n_errors++;
      end else begin
        want_res = consensus_q.pop_front();
        check_field("out_column", DistW'(want_res.out_column), DistW'(res_o.out_column));
        check_field("consensus_base", DistW'(want_res.consensus_base),
                    DistW'(res_o.consensus_base));
        check_field("column_mismatches", DistW'(want_res.column_mismatches),
                    DistW'(res_o.column_mismatches));
        check_field("total_distance", want_res.total_distance, res_o.total_distance);
        check_field("last", DistW'(want_res.last), DistW'(res_o.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_consensus_sequence_hamming_core: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one command beat; start stays high inside a burst, gaps fall between bursts
  task automatic drive_item(input item_t it);
    int unsigned gap;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.op == OP_LOAD) tally_nucleotide(it);
    else emit_consensus();
    n_items++;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_base(input int unsigned col, input logic [BaseW-1:0] b);
    item_t it;
    it.op     = OP_LOAD;
    it.column = ColW'(col);
    it.base   = b;
    drive_item(it);
  endtask

  // column and base are don't-care on a finish, so they get random values
  task automatic finish_seqs();
    item_t it;
    it.op     = OP_FINISH;
    it.column = ColW'($urandom);
    it.base   = BaseW'($urandom);
    drive_item(it);
  endtask

  // drop start, wait for every expected result, then let the tail drain
  task automatic settle();
    start <= 1'b0;
    while (consensus_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LenW-1:0] len);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_len = len;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset length, empty columns read as A with no mismatches
  task automatic test_empty_columns();
    finish_seqs();
  endtask

  // majority vote and tie breaking toward the earlier base
  task automatic test_consensus_ties();
    write_length(LenW'(4));
    load_base(0, BaseA);
    load_base(0, BaseC);
    load_base(1, BaseC);
    load_base(1, BaseG);
    load_base(1, BaseG);
    load_base(1, BaseT);
    load_base(2, BaseT);
    load_base(2, BaseT);
    load_base(2, BaseT);
    load_base(3, BaseT);
    load_base(3, BaseG);
    load_base(3, BaseC);
    load_base(63, BaseT);
    finish_seqs();
    // counters must be clear now
    finish_seqs();
  endtask

  // zero length, one column, oversize length and the maximum
  task automatic test_length_extremes();
    write_length('0);
    load_base(0, BaseG);
    load_base(0, BaseG);
    finish_seqs();
    write_length(LenW'(1));
    finish_seqs();
    write_length('1);
    load_base(63, BaseC);
    load_base(62, BaseT);
    finish_seqs();
    write_length(LenMax + 1'b1);
    finish_seqs();
    write_length(LenMax);
  endtask

  // sets of equal-length sequences around a per-column favorite base, with noise
  task automatic test_random_sets();
    logic [BaseW-1:0] fav [MaxLen];
    int unsigned      stop_at;
    int unsigned      pick;
    int unsigned      len;
    int unsigned      ncols;
    int unsigned      rows;
    stop_at = n_items + RandomItems;
    while (n_items < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 0;
      else if (pick == 1) len = MaxLen;
      else if (pick == 2) len = $urandom_range(MaxLen + 1, 127);
      else if (pick < 6) len = $urandom_range(9, MaxLen - 1);
      else len = $urandom_range(1, 8);
      write_length(LenW'(len));
      ncols = (len > MaxLen) ? MaxLen : len;
      rows  = $urandom_range(1, (ncols == 0) ? 4 : ((120 / ncols > 1) ? 120 / ncols : 1));
      for (int c = 0; c < MaxLen; c++) fav[c] = BaseW'($urandom);
      for (int unsigned r = 0; r < rows; r++) begin
        for (int unsigned c = 0; c < ncols; c++) begin
          if ($urandom_range(0, 9) == 0) begin
            load_base($urandom_range(0, MaxLen - 1), BaseW'($urandom));
          end
          // broken rows skip a nucleotide now and then
          if ($urandom_range(0, 15) != 0) begin
            load_base(c, ($urandom_range(0, 2) == 0) ? BaseW'($urandom) : fav[c]);
          end
        end
        if (ncols == 0) load_base($urandom_range(0, MaxLen - 1), BaseW'($urandom));
      end
      finish_seqs();
      if ($urandom_range(0, 7) == 0) finish_seqs();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    n_errors    = 0;
    n_items     = 0;
    burst_left  = 0;
    cycle_cnt   = 0;
    model_len   = LenMax;
    clear_counts();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_columns();
    test_consensus_ties();
    test_length_extremes();
    test_random_sets();

    settle();
    if (n_errors == 0) begin
      $display("tb_consensus_sequence_hamming_core: PASS");
    end else begin
      $display("tb_consensus_sequence_hamming_core: FAIL");
    end
    $finish;
  end

endmodule
